// ===== design/weno5_z_upwind_flux_assert.svh =====
// assertion macros for the weno-z flux block
`ifndef WENO5_Z_UPWIND_FLUX_ASSERT_SVH
`define WENO5_Z_UPWIND_FLUX_ASSERT_SVH
`ifndef SYNTHESIS
`define WZ_ASSERT_HOLDS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define WZ_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define WZ_ASSERT_HOLDS(name, cond)
`define WZ_ASSERT_IMPL(name, ante, cons)
`endif
`endif

// ===== design/wz_pkg.sv =====
// shared widths, register codes and types of the weno-z flux block
package wz_pkg;
	localparam int ADDR_W = 5;
	localparam int EPS_W = 48;
	localparam int EPS12_W = 52;
	localparam int F_W = 32;
	localparam int ARITH_W = 38;
	localparam int MAG_W = 36;
	localparam int SQ_W = 72;
	localparam int B_W = 80;
	localparam int RDEN_W = 81;
	localparam int RNUM_W = 96;
	localparam int R_W = 32;
	localparam int T_W = 64;
	localparam int M_W = 100;
	localparam int GM_W = 104;
	localparam int FDEN_W = 70;
	localparam int FQ_W = 34;

	typedef enum logic [1:0] {
		REG_EPS_X = 2'd0,
		REG_EPS_Y = 2'd1,
		REG_EPS_Z = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	localparam logic [2:0] G_MINUS [3] = '{3'd3, 3'd6, 3'd1};
	localparam logic [2:0] G_PLUS [3] = '{3'd1, 3'd6, 3'd3};

	typedef struct packed {
		logic [5:0][MAG_W-1:0] pmag;
		logic [5:0] psgn;
		logic act_m;
		logic act_p;
	} side_t;
endpackage

// ===== design/wz_if.sv =====
// stencil and flux channel interfaces
interface wz_stencil_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic [1:0] axis;
	logic signed [DATA_WIDTH-1:0] src_m2, src_m1, src_c, src_p1, src_p2;
	logic signed [DATA_WIDTH-1:0] vel_m2, vel_m1, vel_c, vel_p1, vel_p2;
	modport source (output valid, axis, src_m2, src_m1, src_c, src_p1, src_p2,
		vel_m2, vel_m1, vel_c, vel_p1, vel_p2, input ready);
	modport sink (input valid, axis, src_m2, src_m1, src_c, src_p1, src_p2,
		vel_m2, vel_m1, vel_c, vel_p1, vel_p2, output ready);
endinterface

interface wz_flux_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] flux_minus;
	logic signed [DATA_WIDTH-1:0] flux_plus;
	modport source (output valid, flux_minus, flux_plus, input ready);
	modport sink (input valid, flux_minus, flux_plus, output ready);
endinterface

// ===== design/weno5_z_upwind_flux.sv =====
// top level: weno-z fifth-order upwind flux on one five-point stencil
// channel  dir  width            content
// stencil  in   2+10*DATA_WIDTH  axis, five source and five velocity points
// flux     out  2*DATA_WIDTH     flux at i-1/2 and at i+1/2
// apb      in   64               epsilon registers x, y, z at 0x00, 0x08, 0x10
// pipeline: 7 front stages, 32 ratio divider steps, 6 weighting stages,
// 34 flux divider steps and the output register
// one beat per cycle while the output is not held; each divider stage resolves one quotient bit
// a held output beat freezes every stage, ready follows the output register
// reset clears all valid bits and sets each epsilon register to 1
`include "weno5_z_upwind_flux_assert.svh"
module weno5_z_upwind_flux #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	wz_stencil_if.sink                stencil,
	wz_flux_if.source                 flux,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [wz_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);
	localparam int DW = DATA_WIDTH;
	localparam int PW = (DW < 32) ? DW : 32;

	function automatic logic [wz_pkg::MAG_W-1:0] mag36(
		input logic signed [wz_pkg::ARITH_W-1:0] x);
		mag36 = wz_pkg::MAG_W'(x < 0 ? -x : x);
	endfunction

	logic en;

	// epsilon registers
	logic [wz_pkg::EPS_W-1:0] eps_q [3];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q[0] <= wz_pkg::EPS_W'(1);
			eps_q[1] <= wz_pkg::EPS_W'(1);
			eps_q[2] <= wz_pkg::EPS_W'(1);
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				wz_pkg::REG_EPS_X: eps_q[0] <= pwdata[wz_pkg::EPS_W-1:0];
				wz_pkg::REG_EPS_Y: eps_q[1] <= pwdata[wz_pkg::EPS_W-1:0];
				wz_pkg::REG_EPS_Z: eps_q[2] <= pwdata[wz_pkg::EPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			wz_pkg::REG_EPS_X: prdata = 64'(eps_q[0]);
			wz_pkg::REG_EPS_Y: prdata = 64'(eps_q[1]);
			wz_pkg::REG_EPS_Z: prdata = 64'(eps_q[2]);
			default: prdata = '0;
		endcase
	end

	// s1: magnitude partial products and face direction
	logic signed [DW-1:0] src_w [5];
	logic signed [DW-1:0] vel_w [5];
	logic [63:0] ms_w [5];
	logic [63:0] mv_w [5];
	logic signed [DW:0] fsum_m, fsum_p;

	assign src_w = '{stencil.src_m2, stencil.src_m1, stencil.src_c, stencil.src_p1,
		stencil.src_p2};
	assign vel_w = '{stencil.vel_m2, stencil.vel_m1, stencil.vel_c, stencil.vel_p1,
		stencil.vel_p2};
	assign fsum_m = (DW+1)'(stencil.vel_m1) + (DW+1)'(stencil.vel_c);
	assign fsum_p = (DW+1)'(stencil.vel_p1) + (DW+1)'(stencil.vel_c);

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			ms_w[k] = 64'(unsigned'(src_w[k][DW-1] ? DW'(-src_w[k]) : DW'(src_w[k])));
			mv_w[k] = 64'(unsigned'(vel_w[k][DW-1] ? DW'(-vel_w[k]) : DW'(vel_w[k])));
		end
	end

	logic        v_s1;
	logic [63:0] pp_s1 [5][4];
	logic [4:0]  neg_s1;
	logic        act_m_s1, act_p_s1;
	logic [1:0]  axis_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 5; k++) begin
				pp_s1[k][0] <= 64'(ms_w[k][31:0]) * 64'(mv_w[k][31:0]);
				pp_s1[k][1] <= 64'(ms_w[k][31:0]) * 64'(mv_w[k][63:32]);
				pp_s1[k][2] <= 64'(ms_w[k][63:32]) * 64'(mv_w[k][31:0]);
				pp_s1[k][3] <= 64'(ms_w[k][63:32]) * 64'(mv_w[k][63:32]);
				neg_s1[k] <= src_w[k][DW-1] ^ vel_w[k][DW-1];
			end
			act_m_s1 <= fsum_m < 0;
			act_p_s1 <= fsum_p > 0;
			axis_s1 <= stencil.axis;
		end
	end

	// s2: saturated products f
	logic [127:0] psum_w [5];
	logic [111:0] plim_w [5];
	logic [111:0] pmv_w [5];

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			psum_w[k] = 128'(pp_s1[k][0]) + (128'(pp_s1[k][1]) << 32)
				+ (128'(pp_s1[k][2]) << 32) + (128'(pp_s1[k][3]) << 64);
			plim_w[k] = (112'(1) << (PW-1)) - (neg_s1[k] ? 112'd0 : 112'd1);
			pmv_w[k] = (psum_w[k][127:16] > plim_w[k]) ? plim_w[k] : psum_w[k][127:16];
		end
	end

	logic                           v_s2;
	logic signed [wz_pkg::F_W-1:0]  f_s2 [5];
	logic                           act_m_s2, act_p_s2;
	logic [1:0]                     axis_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 5; k++) begin
				f_s2[k] <= neg_s1[k] ? wz_pkg::F_W'(-pmv_w[k]) : wz_pkg::F_W'(pmv_w[k]);
			end
			act_m_s2 <= act_m_s1;
			act_p_s2 <= act_p_s1;
			axis_s2 <= axis_s1;
		end
	end

	// s3: smoothness differences and candidate stencils
	logic signed [wz_pkg::ARITH_W-1:0] fx [5];
	logic signed [wz_pkg::ARITH_W-1:0] ab_w [6];
	logic signed [wz_pkg::ARITH_W-1:0] cp_w [6];

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			fx[k] = wz_pkg::ARITH_W'(f_s2[k]);
		end
		ab_w[0] = fx[0] - 4 * fx[1] + 3 * fx[2];
		ab_w[1] = fx[0] - 2 * fx[1] + fx[2];
		ab_w[2] = fx[3] - fx[1];
		ab_w[3] = fx[1] - 2 * fx[2] + fx[3];
		ab_w[4] = 3 * fx[2] - 4 * fx[3] + fx[4];
		ab_w[5] = fx[2] - 2 * fx[3] + fx[4];
		cp_w[0] = -fx[0] + 5 * fx[1] + 2 * fx[2];
		cp_w[1] = 2 * fx[1] + 5 * fx[2] - fx[3];
		cp_w[2] = 11 * fx[2] - 7 * fx[3] + 2 * fx[4];
		cp_w[3] = 2 * fx[0] - 7 * fx[1] + 11 * fx[2];
		cp_w[4] = -fx[1] + 5 * fx[2] + 2 * fx[3];
		cp_w[5] = 2 * fx[2] + 5 * fx[3] - fx[4];
	end

	logic                         v_s3;
	logic [wz_pkg::MAG_W-1:0]     ab_s3 [6];
	wz_pkg::side_t                side_s3;
	logic [1:0]                   axis_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				ab_s3[j] <= mag36(ab_w[j]);
				side_s3.pmag[j] <= mag36(cp_w[j]);
				side_s3.psgn[j] <= cp_w[j] < 0;
			end
			side_s3.act_m <= act_m_s2;
			side_s3.act_p <= act_p_s2;
			axis_s3 <= axis_s2;
		end
	end

	// s4: square partial products
	logic          v_s4;
	logic [63:0]   ll_s4 [6];
	logic [35:0]   lh_s4 [6];
	logic [7:0]    hh_s4 [6];
	wz_pkg::side_t side_s4;
	logic [1:0]    axis_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				ll_s4[j] <= 64'(ab_s3[j][31:0]) * 64'(ab_s3[j][31:0]);
				lh_s4[j] <= 36'(ab_s3[j][31:0]) * 36'(ab_s3[j][35:32]);
				hh_s4[j] <= 8'(ab_s3[j][35:32]) * 8'(ab_s3[j][35:32]);
			end
			side_s4 <= side_s3;
			axis_s4 <= axis_s3;
		end
	end

	// s5: twelve times beta
	logic [wz_pkg::SQ_W-1:0] sq_w [6];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			sq_w[j] = wz_pkg::SQ_W'(ll_s4[j]) + (wz_pkg::SQ_W'(lh_s4[j]) << 33)
				+ (wz_pkg::SQ_W'(hh_s4[j]) << 64);
		end
	end

	logic                    v_s5;
	logic [wz_pkg::B_W-1:0]  beta_s5 [3];
	wz_pkg::side_t           side_s5;
	logic [1:0]              axis_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				beta_s5[k] <= (wz_pkg::B_W'(sq_w[2*k]) * wz_pkg::B_W'(3)
					+ wz_pkg::B_W'(sq_w[2*k+1]) * wz_pkg::B_W'(13)) << 8;
			end
			side_s5 <= side_s4;
			axis_s5 <= axis_s4;
		end
	end

	// s6: tau and ratio denominators
	logic [wz_pkg::EPS_W-1:0]   eps_w;
	logic [wz_pkg::EPS12_W-1:0] eps12_w;

	always_comb begin
		case (axis_s5)
			wz_pkg::AXIS_X: eps_w = eps_q[0];
			wz_pkg::AXIS_Y: eps_w = eps_q[1];
			default: eps_w = eps_q[2];
		endcase
		eps12_w = (wz_pkg::EPS12_W'(eps_w) << 3) + (wz_pkg::EPS12_W'(eps_w) << 2);
	end

	logic                       v_s6;
	logic [wz_pkg::B_W-1:0]     tau_s6;
	logic [wz_pkg::RDEN_W-1:0]  rden_s6 [3];
	wz_pkg::side_t              side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			tau_s6 <= (beta_s5[2] >= beta_s5[0]) ? beta_s5[2] - beta_s5[0]
				: beta_s5[0] - beta_s5[2];
			for (int k = 0; k < 3; k++) begin
				rden_s6[k] <= wz_pkg::RDEN_W'(beta_s5[k]) + wz_pkg::RDEN_W'(eps12_w);
			end
			side_s6 <= side_s5;
		end
	end

	// s7: ratio saturation and zero denominator
	logic                       v_s7;
	logic [wz_pkg::RNUM_W-1:0]  rnum_s7 [3];
	logic [wz_pkg::RDEN_W-1:0]  rden_s7 [3];
	logic [2:0]                 rsat_s7, rdz_s7;
	wz_pkg::side_t              side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rsat_s7[k] <= 97'(tau_s6) >= (97'(rden_s6[k]) << 16);
				rdz_s7[k] <= rden_s6[k] == '0;
				rnum_s7[k] <= ((97'(tau_s6) >= (97'(rden_s6[k]) << 16)) || rden_s6[k] == '0)
					? '0 : {tau_s6, 16'd0};
				rden_s7[k] <= rden_s6[k];
			end
			side_s7 <= side_s6;
		end
	end

	// ratio dividers
	logic [2:0]              rv_d;
	logic [wz_pkg::R_W-1:0]  rq_d [3];
	logic [2:0]              rsat_d, rdz_d;
	wz_pkg::side_t           side_d;

	wz_div #(
		.NUM_W(wz_pkg::RNUM_W), .DEN_W(wz_pkg::RDEN_W), .QUO_W(wz_pkg::R_W),
		.SB_W(2 + $bits(wz_pkg::side_t))
	) u_rdiv0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s7),
		.num(rnum_s7[0]), .den(rden_s7[0]),
		.sb_in({rsat_s7[0], rdz_s7[0], side_s7}),
		.out_v(rv_d[0]), .quo(rq_d[0]),
		.sb_out({rsat_d[0], rdz_d[0], side_d})
	);

	genvar gk;
	for (gk = 1; gk < 3; gk++) begin : g_rdiv
		wz_div #(
			.NUM_W(wz_pkg::RNUM_W), .DEN_W(wz_pkg::RDEN_W), .QUO_W(wz_pkg::R_W),
			.SB_W(2)
		) u_rdiv (
			.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s7),
			.num(rnum_s7[gk]), .den(rden_s7[gk]),
			.sb_in({rsat_s7[gk], rdz_s7[gk]}),
			.out_v(rv_d[gk]), .quo(rq_d[gk]),
			.sb_out({rsat_d[gk], rdz_d[gk]})
		);
	end

	// s8: squared ratio
	logic [wz_pkg::R_W-1:0] r_w [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_w[k] = rdz_d[k] ? '0 : (rsat_d[k] ? '1 : rq_d[k]);
		end
	end

	logic                    v_s8;
	logic [wz_pkg::T_W-1:0]  r2_s8 [3];
	wz_pkg::side_t           side_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				r2_s8[k] <= wz_pkg::T_W'(r_w[k]) * wz_pkg::T_W'(r_w[k]);
			end
			side_s8 <= side_d;
		end
	end

	// s9: partial products of r^2 times candidate magnitude
	logic                    v_s9;
	logic [63:0]             pt_s9 [6][4];
	logic [wz_pkg::T_W-1:0]  r2_s9 [3];
	wz_pkg::side_t           side_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				pt_s9[j][0] <= 64'(r2_s8[j%3][31:0]) * 64'(side_s8.pmag[j][31:0]);
				pt_s9[j][1] <= 64'(r2_s8[j%3][63:32]) * 64'(side_s8.pmag[j][31:0]);
				pt_s9[j][2] <= 64'(r2_s8[j%3][31:0]) * 64'(side_s8.pmag[j][35:32]);
				pt_s9[j][3] <= 64'(r2_s8[j%3][63:32]) * 64'(side_s8.pmag[j][35:32]);
			end
			r2_s9 <= r2_s8;
			side_s9 <= side_s8;
		end
	end

	// s10: alpha times candidate magnitude, alpha itself
	logic                    v_s10;
	logic [wz_pkg::M_W-1:0]  m_s10 [6];
	logic [wz_pkg::T_W-1:0]  t_s10 [3];
	wz_pkg::side_t           side_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				m_s10[j] <= wz_pkg::M_W'(pt_s9[j][0])
					+ (wz_pkg::M_W'(pt_s9[j][1]) << 32)
					+ (wz_pkg::M_W'(pt_s9[j][2]) << 32)
					+ (wz_pkg::M_W'(pt_s9[j][3]) << 64)
					+ (wz_pkg::M_W'(side_s9.pmag[j]) << 32);
			end
			for (int k = 0; k < 3; k++) begin
				t_s10[k] <= r2_s9[k] + (wz_pkg::T_W'(1) << 32);
			end
			side_s10 <= side_s9;
		end
	end

	// s11: gamma weighting and flux denominators
	logic                       v_s11;
	logic [wz_pkg::GM_W-1:0]    gm_s11 [6];
	logic [wz_pkg::FDEN_W-1:0]  fden_s11 [2];
	logic [5:0]                 psgn_s11;
	logic                       act_m_s11, act_p_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				gm_s11[k] <= wz_pkg::GM_W'(m_s10[k]) * wz_pkg::GM_W'(wz_pkg::G_MINUS[k]);
				gm_s11[3+k] <= wz_pkg::GM_W'(m_s10[3+k]) * wz_pkg::GM_W'(wz_pkg::G_PLUS[k]);
			end
			fden_s11[0] <= (wz_pkg::FDEN_W'(t_s10[0]) * wz_pkg::FDEN_W'(3)
				+ wz_pkg::FDEN_W'(t_s10[1]) * wz_pkg::FDEN_W'(6)
				+ wz_pkg::FDEN_W'(t_s10[2])) * wz_pkg::FDEN_W'(6);
			fden_s11[1] <= (wz_pkg::FDEN_W'(t_s10[0])
				+ wz_pkg::FDEN_W'(t_s10[1]) * wz_pkg::FDEN_W'(6)
				+ wz_pkg::FDEN_W'(t_s10[2]) * wz_pkg::FDEN_W'(3)) * wz_pkg::FDEN_W'(6);
			psgn_s11 <= side_s10.psgn;
			act_m_s11 <= side_s10.act_m;
			act_p_s11 <= side_s10.act_p;
		end
	end

	// s12: positive and negative sums per face
	logic [wz_pkg::GM_W-1:0] pos_w [2];
	logic [wz_pkg::GM_W-1:0] ngs_w [2];

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			pos_w[h] = '0;
			ngs_w[h] = '0;
			for (int k = 0; k < 3; k++) begin
				pos_w[h] = pos_w[h] + (psgn_s11[3*h+k] ? '0 : gm_s11[3*h+k]);
				ngs_w[h] = ngs_w[h] + (psgn_s11[3*h+k] ? gm_s11[3*h+k] : '0);
			end
		end
	end

	logic                       v_s12;
	logic [wz_pkg::GM_W-1:0]    pos_s12 [2];
	logic [wz_pkg::GM_W-1:0]    ngs_s12 [2];
	logic [wz_pkg::FDEN_W-1:0]  fden_s12 [2];
	logic                       act_m_s12, act_p_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s12 <= pos_w;
			ngs_s12 <= ngs_w;
			fden_s12 <= fden_s11;
			act_m_s12 <= act_m_s11;
			act_p_s12 <= act_p_s11;
		end
	end

	// s13: signed magnitude of the weighted sum
	logic                       v_s13;
	logic [wz_pkg::GM_W-1:0]    fmag_s13 [2];
	logic [wz_pkg::FDEN_W-1:0]  fden_s13 [2];
	logic [1:0]                 fneg_s13;
	logic                       act_m_s13, act_p_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int h = 0; h < 2; h++) begin
				fneg_s13[h] <= pos_s12[h] < ngs_s12[h];
				fmag_s13[h] <= (pos_s12[h] >= ngs_s12[h]) ? pos_s12[h] - ngs_s12[h]
					: ngs_s12[h] - pos_s12[h];
			end
			fden_s13 <= fden_s12;
			act_m_s13 <= act_m_s12;
			act_p_s13 <= act_p_s12;
		end
	end

	// flux dividers
	logic                     fv_m, fv_p;
	logic [wz_pkg::FQ_W-1:0]  fq_m, fq_p;
	logic                     fneg_m_d, act_m_d, fneg_p_d, act_p_d;

	wz_div #(
		.NUM_W(wz_pkg::GM_W), .DEN_W(wz_pkg::FDEN_W), .QUO_W(wz_pkg::FQ_W), .SB_W(2)
	) u_fdiv_m (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s13),
		.num(fmag_s13[0]), .den(fden_s13[0]), .sb_in({fneg_s13[0], act_m_s13}),
		.out_v(fv_m), .quo(fq_m), .sb_out({fneg_m_d, act_m_d})
	);

	wz_div #(
		.NUM_W(wz_pkg::GM_W), .DEN_W(wz_pkg::FDEN_W), .QUO_W(wz_pkg::FQ_W), .SB_W(2)
	) u_fdiv_p (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s13),
		.num(fmag_s13[1]), .den(fden_s13[1]), .sb_in({fneg_s13[1], act_p_s13}),
		.out_v(fv_p), .quo(fq_p), .sb_out({fneg_p_d, act_p_d})
	);

	// s14: output saturation
	logic [65:0] olim_m, olim_p, oval_m, oval_p, ores_m, ores_p;

	always_comb begin
		olim_m = (66'(1) << (DW-1)) - 66'd1 + (fneg_m_d ? 66'd1 : 66'd0);
		olim_p = (66'(1) << (DW-1)) - 66'd1 + (fneg_p_d ? 66'd1 : 66'd0);
		oval_m = (66'(fq_m) > olim_m) ? olim_m : 66'(fq_m);
		oval_p = (66'(fq_p) > olim_p) ? olim_p : 66'(fq_p);
		ores_m = fneg_m_d ? -oval_m : oval_m;
		ores_p = fneg_p_d ? -oval_p : oval_p;
	end

	logic          v_s14;
	logic [DW-1:0] flux_m_s14, flux_p_s14;
	logic [1:0]    act_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			flux_m_s14 <= act_m_d ? DW'(ores_m) : '0;
			flux_p_s14 <= act_p_d ? DW'(ores_p) : '0;
			act_s14 <= {act_p_d, act_m_d};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s1 <= stencil.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= rv_d[0];
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= fv_m;
		end
	end

	assign en = !v_s14 || flux.ready;
	assign stencil.ready = en;
	assign flux.valid = v_s14;
	assign flux.flux_minus = flux_m_s14;
	assign flux.flux_plus = flux_p_s14;

	`WZ_ASSERT_HOLDS(a_ratio_lanes_agree, rv_d[0] == rv_d[1] && rv_d[0] == rv_d[2])
	`WZ_ASSERT_HOLDS(a_flux_lanes_agree, fv_m == fv_p)
	`WZ_ASSERT_IMPL(a_flux_den_nonzero, v_s12, fden_s12[0] != '0 && fden_s12[1] != '0)
	`WZ_ASSERT_IMPL(a_idle_face_zero, v_s14 && !act_s14[0], flux_m_s14 == '0)
endmodule

// ===== design/wz_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module wz_div #(
	parameter int NUM_W = 96,
	parameter int DEN_W = 81,
	parameter int QUO_W = 32,
	parameter int SB_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  sb_in,
	output logic             out_v,
	output logic [QUO_W-1:0] quo,
	output logic [SB_W-1:0]  sb_out
);
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] q_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [SB_W-1:0]  sb_s [QUO_W];
	logic [QUO_W-1:0] v_s;

	genvar i;
	for (i = 0; i < QUO_W; i++) begin : g_step
		logic [DEN_W-1:0] rem_i, den_i;
		logic [QUO_W-1:0] low_i, q_i;
		logic [SB_W-1:0]  sb_i;
		logic             v_i;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_i = DEN_W'(num >> QUO_W);
			assign low_i = num[QUO_W-1:0];
			assign q_i = '0;
			assign den_i = den;
			assign sb_i = sb_in;
			assign v_i = in_v;
		end else begin : g_next
			assign rem_i = rem_s[i-1];
			assign low_i = low_s[i-1];
			assign q_i = q_s[i-1];
			assign den_i = den_s[i-1];
			assign sb_i = sb_s[i-1];
			assign v_i = v_s[i-1];
		end

		assign trial = {rem_i, low_i[QUO_W-1]};
		assign ge = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
				low_s[i] <= low_i << 1;
				q_s[i] <= {q_i[QUO_W-2:0], ge};
				den_s[i] <= den_i;
				sb_s[i] <= sb_i;
			end
		end
	end

	assign out_v = v_s[QUO_W-1];
	assign quo = q_s[QUO_W-1];
	assign sb_out = sb_s[QUO_W-1];
endmodule
